@@ rtl/core/rwtd_pkg.sv @@
package rwtd_pkg;

	localparam int ID_BITS = 4;
	localparam int TAG_OUT_BITS = 16;
	localparam int READER_BITS = 8;
	localparam logic [READER_BITS-1:0] READER_MAX = 8'd255;

	typedef enum logic [1:0] {
		CMD_SUBMIT   = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_COMPLETE = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NONE_READY = 2'd2,
		ST_NO_TASK    = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                    command;
		logic [ID_BITS-1:0]      resource_id;
		logic                    access_kind;
		logic [TAG_OUT_BITS-1:0] task_tag;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic                    issued_valid;
		logic [ID_BITS-1:0]      issued_resource;
		logic                    issued_kind;
		logic [TAG_OUT_BITS-1:0] issued_tag;
	} rsp_t;

	typedef struct packed {
		status_t            status;
		logic               issued_valid;
		logic [ID_BITS-1:0] issued_resource;
		logic               issued_kind;
	} result_t;

endpackage

@@ rtl/core/rwtd_ram.sv @@
module rwtd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/rwtd_core.sv @@
module rwtd_core #(
	parameter int NUM_RESOURCES = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         go,
	input  rwtd_pkg::req_t                               item,
	output rwtd_pkg::result_t                            result,
	output logic                                         slot_we,
	output logic [$clog2(NUM_RESOURCES*QUEUE_DEPTH)-1:0] slot_waddr,
	output logic [$clog2(NUM_RESOURCES*QUEUE_DEPTH)-1:0] slot_raddr
);

	localparam int RES_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int RCW = $clog2(NUM_RESOURCES + 1);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_RESOURCES * QUEUE_DEPTH);
	localparam int RB = rwtd_pkg::READER_BITS;

	logic [QW-1:0]          qhead_q [NUM_RESOURCES];
	logic [CW-1:0]          qcount_q [NUM_RESOURCES];
	logic [RB-1:0]          readers_q [NUM_RESOURCES];
	logic [NUM_RESOURCES-1:0] writer_q;
	logic [NUM_RESOURCES-1:0] onring_q;
	logic [QUEUE_DEPTH-1:0] kinds_q [NUM_RESOURCES];
	logic [RES_W-1:0]       ring_q [NUM_RESOURCES];
	logic [RES_W-1:0]       rhead_q;
	logic [RCW-1:0]         rcount_q;

	rwtd_pkg::cmd_t    cmd;
	rwtd_pkg::status_t status;
	logic              id_ok;
	logic [RES_W-1:0]  rid;
	logic [RES_W-1:0]  d;
	logic [RES_W-1:0]  sel;
	logic [QW-1:0]     qh;
	logic [QW-1:0]     qh_inc;
	logic [QW-1:0]     qh_n;
	logic [QW-1:0]     pos;
	logic [CW:0]       pos_sum;
	logic [CW-1:0]     qc;
	logic [CW-1:0]     qc_n;
	logic [RB-1:0]     rr;
	logic [RB-1:0]     rr_n;
	logic              wr;
	logic              wr_n;
	logic              onr;
	logic              onr_eff;
	logic [QUEUE_DEPTH-1:0] kr;
	logic [QUEUE_DEPTH-1:0] kr_n;
	logic              head_kind;
	logic              ready_now;
	logic              ready_after;
	logic              ring_empty;
	logic              pop;
	logic              upd;
	logic              we;
	logic              push;
	logic              iv;
	logic [RCW-1:0]    rcount_eff;
	logic [RCW:0]      tail_sum;
	logic [RES_W-1:0]  tail;
	logic [RES_W-1:0]  rhead_inc;
	logic [AW-1:0]     base;

	always_comb begin
		cmd = item.command;
		id_ok = (int'(item.resource_id) < NUM_RESOURCES);
		rid = RES_W'(item.resource_id);
		ring_empty = (rcount_q == '0);
		d = ring_q[rhead_q];
		sel = (cmd == rwtd_pkg::CMD_DISPATCH) ? d : rid;

		qh = qhead_q[sel];
		qc = qcount_q[sel];
		rr = readers_q[sel];
		wr = writer_q[sel];
		onr = onring_q[sel];
		kr = kinds_q[sel];
		head_kind = kr[qh];
		ready_now = (qc != '0) && !wr &&
			(head_kind ? (rr == '0) : (rr != rwtd_pkg::READER_MAX));

		pos_sum = (CW+1)'(qh) + (CW+1)'(qc);
		pos = (pos_sum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(pos_sum - (CW+1)'(QUEUE_DEPTH))
			: QW'(pos_sum);
		qh_inc = (qh == QW'(QUEUE_DEPTH - 1)) ? '0 : qh + 1'b1;

		qh_n = qh;
		qc_n = qc;
		rr_n = rr;
		wr_n = wr;
		kr_n = kr;
		status = rwtd_pkg::ST_OK;
		iv = 1'b0;
		pop = 1'b0;
		upd = 1'b0;
		we = 1'b0;

		case (cmd)
			rwtd_pkg::CMD_SUBMIT: begin
				if (!id_ok || qc >= CW'(QUEUE_DEPTH)) begin
					status = rwtd_pkg::ST_FULL;
				end else begin
					upd = 1'b1;
					we = 1'b1;
					qc_n = qc + 1'b1;
					kr_n[pos] = item.access_kind;
				end
			end
			rwtd_pkg::CMD_DISPATCH: begin
				if (ring_empty) begin
					status = rwtd_pkg::ST_NONE_READY;
				end else begin
					pop = 1'b1;
					if (!ready_now) begin
						status = rwtd_pkg::ST_NONE_READY;
					end else begin
						upd = 1'b1;
						iv = 1'b1;
						qh_n = qh_inc;
						qc_n = qc - 1'b1;
						if (head_kind) begin
							wr_n = 1'b1;
						end else begin
							rr_n = rr + 1'b1;
						end
					end
				end
			end
			rwtd_pkg::CMD_COMPLETE: begin
				if (!id_ok) begin
					status = rwtd_pkg::ST_NO_TASK;
				end else if (!item.access_kind) begin
					if (rr == '0) begin
						status = rwtd_pkg::ST_NO_TASK;
					end else begin
						upd = 1'b1;
						rr_n = rr - 1'b1;
					end
				end else if (!wr) begin
					status = rwtd_pkg::ST_NO_TASK;
				end else begin
					upd = 1'b1;
					wr_n = 1'b0;
				end
			end
			default: begin
			end
		endcase

		ready_after = (qc_n != '0) && !wr_n &&
			(kr_n[qh_n] ? (rr_n == '0) : (rr_n != rwtd_pkg::READER_MAX));
		onr_eff = (cmd == rwtd_pkg::CMD_DISPATCH) ? 1'b0 : onr;
		rcount_eff = rcount_q - RCW'(pop);
		push = upd && !onr_eff && ready_after && (rcount_eff < RCW'(NUM_RESOURCES));

		// A pop alone leaves the tail where it was; a push moves it on by one slot.
		tail_sum = (RCW+1)'(rhead_q) + (RCW+1)'(rcount_q);
		tail = (tail_sum >= (RCW+1)'(NUM_RESOURCES))
			? RES_W'(tail_sum - (RCW+1)'(NUM_RESOURCES)) : RES_W'(tail_sum);
		rhead_inc = (rhead_q == RES_W'(NUM_RESOURCES - 1)) ? '0 : rhead_q + 1'b1;

		base = AW'(sel) * AW'(QUEUE_DEPTH);
		slot_waddr = base + AW'(pos);
		slot_raddr = base + AW'(qh);
		slot_we = go && we;

		result.status = status;
		result.issued_valid = iv;
		result.issued_resource = iv ? rwtd_pkg::ID_BITS'(d) : '0;
		result.issued_kind = iv ? head_kind : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				qhead_q[i] <= '0;
				qcount_q[i] <= '0;
				readers_q[i] <= '0;
			end
			writer_q <= '0;
			onring_q <= '0;
			rhead_q <= '0;
			rcount_q <= '0;
		end else if (go) begin
			if (upd) begin
				qhead_q[sel] <= qh_n;
				qcount_q[sel] <= qc_n;
				readers_q[sel] <= rr_n;
				writer_q[sel] <= wr_n;
			end
			if (pop) begin
				rhead_q <= rhead_inc;
			end
			if (pop || push) begin
				onring_q[sel] <= push;
			end
			rcount_q <= rcount_eff + RCW'(push);
		end
	end

	always_ff @(posedge clk) begin
		if (go && we) begin
			kinds_q[sel] <= kr_n;
		end
		if (go && push) begin
			ring_q[tail] <= sel;
		end
	end

endmodule

@@ rtl/core/reader_writer_task_dispatcher.sv @@
// Channel  Direction  Payload               Handshake
// req      in         rwtd_pkg::req_t       req_valid / req_ready
// rsp      out        rwtd_pkg::rsp_t       rsp_valid / rsp_ready
//
// One command is taken per cycle unless the result side stalls; its result passes
// through the input register and the result register. The rate is set by one pass
// through the per-resource state and the ring head, with the task tag read from the
// slot RAM into the result stage. Reset clears queue heads and counts, reader, writer
// and ring control state at once; no clearing pass. While a result waits on rsp_ready,
// it and the input register hold, and req_ready drops once both are occupied.
module reader_writer_task_dispatcher #(
	parameter int NUM_RESOURCES = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int TAG_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rwtd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rwtd_pkg::rsp_t rsp
);

	localparam int AW = $clog2(NUM_RESOURCES * QUEUE_DEPTH);

	logic              valid_s1;
	rwtd_pkg::req_t    req_s1;
	logic              valid_s2;
	rwtd_pkg::result_t result_s2;
	rwtd_pkg::result_t result;
	logic              advance;
	logic              go;
	logic              slot_we;
	logic [AW-1:0]     slot_waddr;
	logic [AW-1:0]     slot_raddr;
	logic [TAG_BITS-1:0] slot_rdata;

	assign advance = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign go = valid_s1 && advance;
	assign rsp_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	rwtd_core #(
		.NUM_RESOURCES(NUM_RESOURCES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.item(req_s1),
		.result(result),
		.slot_we(slot_we),
		.slot_waddr(slot_waddr),
		.slot_raddr(slot_raddr)
	);

	rwtd_ram #(
		.WIDTH(TAG_BITS),
		.DEPTH(NUM_RESOURCES * QUEUE_DEPTH)
	) u_slots (
		.clk(clk),
		.we(slot_we),
		.waddr(slot_waddr),
		.wdata(TAG_BITS'(req_s1.task_tag)),
		.re(advance),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	always_comb begin
		rsp.status = result_s2.status;
		rsp.issued_valid = result_s2.issued_valid;
		rsp.issued_resource = result_s2.issued_resource;
		rsp.issued_kind = result_s2.issued_kind;
		rsp.issued_tag = result_s2.issued_valid ? rwtd_pkg::TAG_OUT_BITS'(slot_rdata) : '0;
	end

	a_issue_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.issued_valid |-> rsp.status == rwtd_pkg::ST_OK)
		else $error("Issued task reported with a failing status.");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("Input stalled while the output side was free.");

	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> valid_s2)
		else $error("A command left the input register without a result.");

	a_issue_only_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		go && req_s1.command != rwtd_pkg::CMD_DISPATCH |=> !result_s2.issued_valid)
		else $error("A task was issued by a command other than dispatch.");

endmodule

@@ test/rwtd_tracker_pkg.sv @@
`timescale 1ns / 100ps

package rwtd_tracker_pkg;

	localparam int NRES = 1 << rwtd_pkg::ID_BITS;
	localparam int QDEPTH = 8;

	class dispatch_tracker;
		logic                              slot_kind [NRES][QDEPTH];
		logic [rwtd_pkg::TAG_OUT_BITS-1:0] slot_tag [NRES][QDEPTH];
		logic [2:0]                        q_head [NRES];
		logic [3:0]                        q_fill [NRES];
		logic [rwtd_pkg::READER_BITS-1:0]  readers [NRES];
		bit                                writer_on [NRES];
		bit                                on_ring [NRES];
		logic [rwtd_pkg::ID_BITS-1:0]      ring [NRES];
		logic [rwtd_pkg::ID_BITS-1:0]      ring_head;
		logic [rwtd_pkg::ID_BITS:0]        ring_fill;
		rwtd_pkg::rsp_t                    outcome_q [$];
		int                                errors;

		function new();
			for (int r = 0; r < NRES; r++) begin
				q_head[r] = '0;
				q_fill[r] = '0;
				readers[r] = '0;
				writer_on[r] = 1'b0;
				on_ring[r] = 1'b0;
				ring[r] = '0;
			end
			ring_head = '0;
			ring_fill = '0;
			errors = 0;
		endfunction

		function bit can_start(logic [rwtd_pkg::ID_BITS-1:0] r);
			if (q_fill[r] == 0 || writer_on[r]) begin
				return 1'b0;
			end
			if (slot_kind[r][q_head[r]] == 1'b0) begin
				return readers[r] != rwtd_pkg::READER_MAX;
			end
			return readers[r] == 0;
		endfunction

		function void ring_join(logic [rwtd_pkg::ID_BITS-1:0] r);
			logic [rwtd_pkg::ID_BITS-1:0] pos;
			if (!on_ring[r] && can_start(r) && ring_fill < NRES) begin
				pos = ring_head + ring_fill[rwtd_pkg::ID_BITS-1:0];
				ring[pos] = r;
				ring_fill++;
				on_ring[r] = 1'b1;
			end
		endfunction

		function void take_command(rwtd_pkg::req_t c);
			rwtd_pkg::rsp_t               e;
			logic [rwtd_pkg::ID_BITS-1:0] r;
			logic [rwtd_pkg::ID_BITS-1:0] d;
			logic [2:0]                   pos;
			e = '0;
			e.status = rwtd_pkg::ST_OK;
			r = c.resource_id;
			case (c.command)
			rwtd_pkg::CMD_SUBMIT: begin
				if (q_fill[r] == QDEPTH) begin
					e.status = rwtd_pkg::ST_FULL;
				end else begin
					pos = q_head[r] + q_fill[r][2:0];
					slot_kind[r][pos] = c.access_kind;
					slot_tag[r][pos] = c.task_tag;
					q_fill[r]++;
					ring_join(r);
				end
			end
			rwtd_pkg::CMD_DISPATCH: begin
				if (ring_fill == 0) begin
					e.status = rwtd_pkg::ST_NONE_READY;
				end else begin
					d = ring[ring_head];
					ring_head++;
					ring_fill--;
					on_ring[d] = 1'b0;
					if (!can_start(d)) begin
						e.status = rwtd_pkg::ST_NONE_READY;
					end else begin
						e.issued_valid = 1'b1;
						e.issued_resource = d;
						e.issued_kind = slot_kind[d][q_head[d]];
						e.issued_tag = slot_tag[d][q_head[d]];
						q_head[d]++;
						q_fill[d]--;
						if (e.issued_kind == 1'b0) begin
							readers[d]++;
						end else begin
							writer_on[d] = 1'b1;
						end
						ring_join(d);
					end
				end
			end
			rwtd_pkg::CMD_COMPLETE: begin
				if (c.access_kind == 1'b0) begin
					if (readers[r] == 0) begin
						e.status = rwtd_pkg::ST_NO_TASK;
					end else begin
						readers[r]--;
						ring_join(r);
					end
				end else begin
					if (!writer_on[r]) begin
						e.status = rwtd_pkg::ST_NO_TASK;
					end else begin
						writer_on[r] = 1'b0;
						ring_join(r);
					end
				end
			end
			default: begin
			end
			endcase
			outcome_q.push_back(e);
		endfunction

		function void check_outcome(rwtd_pkg::rsp_t got);
			rwtd_pkg::rsp_t e;
			if (outcome_q.size() == 0) begin
				$error("result transfer with no command pending: status %0d", got.status);
				errors++;
				return;
			end
			e = outcome_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.issued_valid !== e.issued_valid) begin
				$error("issued_valid: expected %0d, actual %0d", e.issued_valid,
					got.issued_valid);
				errors++;
			end
			if (got.issued_resource !== e.issued_resource) begin
				$error("issued_resource: expected %0d, actual %0d", e.issued_resource,
					got.issued_resource);
				errors++;
			end
			if (got.issued_kind !== e.issued_kind) begin
				$error("issued_kind: expected %0d, actual %0d", e.issued_kind,
					got.issued_kind);
				errors++;
			end
			if (got.issued_tag !== e.issued_tag) begin
				$error("issued_tag: expected %0h, actual %0h", e.issued_tag, got.issued_tag);
				errors++;
			end
		endfunction
	endclass

endpackage

@@ test/reader_writer_task_dispatcher_tb.sv @@
`timescale 1ns / 100ps

module reader_writer_task_dispatcher_tb;

	localparam int NRES = rwtd_tracker_pkg::NRES;
	localparam int QDEPTH = rwtd_tracker_pkg::QDEPTH;
	localparam logic [rwtd_pkg::ID_BITS-1:0] SAT_RES = 4'd9;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rwtd_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rwtd_pkg::rsp_t rsp;

	rwtd_tracker_pkg::dispatch_tracker tracker = new();
	int burst_left = 0;
	bit hold_rsp = 1'b0;

	reader_writer_task_dispatcher #(
		.NUM_RESOURCES(NRES),
		.QUEUE_DEPTH(QDEPTH),
		.TAG_BITS(rwtd_pkg::TAG_OUT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			tracker.check_outcome(rsp);
		end
	end

	initial begin : result_side
		int left;
		int mode;
		int phase;
		left = 0;
		mode = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(3, 0);
					left = $urandom_range(60, 10);
				end
				left--;
				phase++;
				case (mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(1, 0));
				2: rsp_ready <= ($urandom_range(3, 0) == 0);
				default: rsp_ready <= (phase % 5) != 0;
				endcase
			end
		end
	end

	task automatic send_command(input rwtd_pkg::cmd_t op, input int res, input int kind,
		input int tag);
		rwtd_pkg::req_t c;
		c.command = op;
		c.resource_id = rwtd_pkg::ID_BITS'(res);
		c.access_kind = 1'(kind);
		c.task_tag = rwtd_pkg::TAG_OUT_BITS'(tag);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = $urandom_range(40, 1);
		end
		burst_left--;
		req <= c;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		tracker.take_command(c);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (tracker.outcome_q.size() != 0);
	endtask

	function automatic rwtd_pkg::req_t next_random();
		rwtd_pkg::req_t               c;
		int                           pick;
		int                           start;
		logic [rwtd_pkg::ID_BITS-1:0] r;
		c.command = rwtd_pkg::CMD_NOP;
		c.resource_id = rwtd_pkg::ID_BITS'($urandom_range(NRES - 1, 0));
		c.access_kind = 1'($urandom_range(1, 0));
		c.task_tag = rwtd_pkg::TAG_OUT_BITS'($urandom_range(65535, 0));
		pick = $urandom_range(99, 0);
		if (pick < 36) begin
			c.command = rwtd_pkg::CMD_SUBMIT;
			if ($urandom_range(1, 0) == 1) begin
				c.resource_id = rwtd_pkg::ID_BITS'($urandom_range(3, 0));
			end
			c.access_kind = ($urandom_range(9, 0) < 3);
		end else if (pick < 70) begin
			c.command = rwtd_pkg::CMD_DISPATCH;
		end else if (pick < 94) begin
			c.command = rwtd_pkg::CMD_COMPLETE;
			if ($urandom_range(4, 0) != 0) begin
				start = $urandom_range(NRES - 1, 0);
				for (int i = 0; i < NRES; i++) begin
					r = rwtd_pkg::ID_BITS'(start + i);
					if (tracker.writer_on[r] || tracker.readers[r] != 0) begin
						c.resource_id = r;
						c.access_kind = tracker.writer_on[r];
						break;
					end
				end
			end
		end
		return c;
	endfunction

	initial begin : stimulus
		rwtd_pkg::req_t c;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		send_command(rwtd_pkg::CMD_COMPLETE, 0, 0, 0);
		send_command(rwtd_pkg::CMD_COMPLETE, 15, 1, 16'hffff);
		send_command(rwtd_pkg::CMD_NOP, 15, 1, 16'hffff);
		send_command(rwtd_pkg::CMD_SUBMIT, 0, 0, 16'h0000);
		send_command(rwtd_pkg::CMD_SUBMIT, 0, 1, 16'hffff);
		send_command(rwtd_pkg::CMD_SUBMIT, 15, 1, 16'ha5a5);
		send_command(rwtd_pkg::CMD_SUBMIT, 15, 0, 16'h5a5a);
		send_command(rwtd_pkg::CMD_DISPATCH, 15, 1, 16'hffff);
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		send_command(rwtd_pkg::CMD_COMPLETE, 15, 1, 0);
		send_command(rwtd_pkg::CMD_COMPLETE, 0, 0, 0);
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		for (int i = 0; i < QDEPTH + 1; i++) begin
			send_command(rwtd_pkg::CMD_SUBMIT, 7, i % 2, $urandom_range(65535, 0));
		end

		// Drive one resource to the reader limit, then watch it stall and recover.
		repeat (264) begin
			send_command(rwtd_pkg::CMD_SUBMIT, SAT_RES, 0, $urandom_range(65535, 0));
			send_command(rwtd_pkg::CMD_DISPATCH, $urandom_range(NRES - 1, 0),
				$urandom_range(1, 0), $urandom_range(65535, 0));
		end
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);
		send_command(rwtd_pkg::CMD_SUBMIT, SAT_RES, 1, $urandom_range(65535, 0));
		wait_drained();

		hold_rsp = 1'b1;
		repeat (258) begin
			send_command(rwtd_pkg::CMD_COMPLETE, SAT_RES, 0, $urandom_range(65535, 0));
		end
		send_command(rwtd_pkg::CMD_DISPATCH, 0, 0, 0);

		for (int i = 0; i < 540; i++) begin
			if (i == 270) begin
				wait_drained();
			end
			c = next_random();
			send_command(c.command, c.resource_id, c.access_kind, c.task_tag);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.outcome_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
